// File: rtl/sdtc_pkg.sv
// shared types and constants for the short descriptor translation check
`default_nettype none

package sdtc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MMU_ENABLE     = 3'd0,
        CFG_ARCH_V6        = 3'd1,
        CFG_DOMAIN_ACCESS  = 3'd2,
        CFG_ROM_PROTECT    = 3'd3,
        CFG_SYSTEM_PROTECT = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // access kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;

    // reported fault kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_FETCH = 2'd3;

    // fault status codes
    localparam logic [3:0] CODE_NONE       = 4'h0;
    localparam logic [3:0] CODE_SEC_TRANS  = 4'h5;
    localparam logic [3:0] CODE_PAGE_TRANS = 4'h7;
    localparam logic [3:0] CODE_SEC_DOM    = 4'h9;
    localparam logic [3:0] CODE_PAGE_DOM   = 4'hb;
    localparam logic [3:0] CODE_SEC_PERM   = 4'hd;
    localparam logic [3:0] CODE_PAGE_PERM  = 4'hf;

    // domain access values
    localparam logic [1:0] DACC_NONE     = 2'd0;
    localparam logic [1:0] DACC_CLIENT   = 2'd1;
    localparam logic [1:0] DACC_RESERVED = 2'd2;
    localparam logic [1:0] DACC_MANAGER  = 2'd3;

    // first-level descriptor types
    localparam logic [1:0] L1_FAULT   = 2'd0;
    localparam logic [1:0] L1_COARSE  = 2'd1;
    localparam logic [1:0] L1_SECTION = 2'd2;
    localparam logic [1:0] L1_FINE    = 2'd3;

    // second-level descriptor types
    localparam logic [1:0] L2_FAULT = 2'd0;
    localparam logic [1:0] L2_LARGE = 2'd1;
    localparam logic [1:0] L2_SMALL = 2'd2;
    localparam logic [1:0] L2_TINY  = 2'd3;

    localparam int REQ_TDATA_W = 104;
    localparam int RSP_TDATA_W = 88;

    typedef struct packed {
        logic        mmu_enable;
        logic        arch_v6;
        logic [31:0] domain_access;
        logic        rom_protect;
        logic        system_protect;
    } t_cfg;

    typedef struct packed {
        logic [31:0] virt_addr;
        logic [31:0] first_level_desc;
        logic [31:0] second_level_desc;
        logic [1:0]  mode;
        logic        privileged;
        logic        record_fault;
    } t_req;

    typedef struct packed {
        logic [31:0] phys_addr;
        logic [1:0]  fault_kind;
        logic [11:0] fault_status;
        logic [31:0] fault_address;
        logic        set_data_regs;
        logic        set_instr_regs;
        logic        unsupported;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/sdtc_cfg.sv
// configuration registers of the translation check
`default_nettype none

module sdtc_cfg
    import sdtc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MMU_ENABLE:     n_cfg.mmu_enable     = i_cfg_data[0];
                CFG_ARCH_V6:        n_cfg.arch_v6        = i_cfg_data[0];
                CFG_DOMAIN_ACCESS:  n_cfg.domain_access  = i_cfg_data;
                CFG_ROM_PROTECT:    n_cfg.rom_protect    = i_cfg_data[0];
                CFG_SYSTEM_PROTECT: n_cfg.system_protect = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sdtc_check.sv
// descriptor walk decode, domain and permission check, fault reporting
`default_nettype none

module sdtc_check
    import sdtc_pkg::*;
(
    input  t_cfg i_cfg,
    input  t_req i_req,
    output t_rsp o_rsp
);

    // v5 access permission encodings
    localparam logic [1:0] AP5_SPECIAL = 2'd0;
    localparam logic [1:0] AP5_PRIV    = 2'd1;
    localparam logic [1:0] AP5_USER_RO = 2'd2;
    localparam logic [1:0] AP5_FULL    = 2'd3;

    // v6 access permission encodings (apx in the top bit)
    localparam logic [2:0] AP6_PRIV    = 3'd1;
    localparam logic [2:0] AP6_USER_RO = 3'd2;
    localparam logic [2:0] AP6_FULL    = 3'd3;
    localparam logic [2:0] AP6_PRIV_RO = 3'd5;
    localparam logic [2:0] AP6_RO      = 3'd6;
    localparam logic [2:0] AP6_RO_ALT  = 3'd7;

    function automatic logic perm_v5(input logic [1:0] ap, input logic kern, input logic wr,
                                     input logic rom, input logic sys);
        logic ok;
        case (ap)
            AP5_SPECIAL: ok = rom ? !wr : (sys & kern & !wr);
            AP5_PRIV:    ok = kern;
            AP5_USER_RO: ok = kern | !wr;
            AP5_FULL:    ok = 1'b1;
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic perm_v6(input logic [2:0] ap, input logic kern, input logic wr);
        logic ok;
        case (ap) inside
            AP6_PRIV:           ok = kern;
            AP6_USER_RO:        ok = kern | !wr;
            AP6_FULL:           ok = 1'b1;
            AP6_PRIV_RO:        ok = kern & !wr;
            AP6_RO, AP6_RO_ALT: ok = !wr;
            default:            ok = 1'b0;
        endcase
        return ok;
    endfunction

    logic        wr;
    logic        fetch;
    logic [3:0]  dom;
    logic [3:0]  dom_rep;
    logic [1:0]  dacc;
    logic        dom_fail;
    logic [1:0]  t1;
    logic [1:0]  t2;
    logic [2:0]  sec_ap;
    logic [2:0]  page_ap;
    logic [1:0]  sub;
    logic [7:0]  sub_aps;
    logic        sec_ok;
    logic        page_ok;
    logic [3:0]  code;
    logic        unsup;
    logic [31:0] pa;

    assign wr    = (i_req.mode == MODE_WRITE);
    assign fetch = (i_req.mode == MODE_FETCH);
    assign dom   = i_req.first_level_desc[8:5];
    assign dacc  = i_cfg.domain_access[{dom, 1'b0} +: 2];
    assign dom_fail = (dacc == DACC_NONE) || (dacc == DACC_RESERVED);
    assign t1    = i_req.first_level_desc[1:0];
    assign t2    = i_req.second_level_desc[1:0];

    // access permission of the section and of the page
    assign sec_ap  = {i_cfg.arch_v6 & i_req.first_level_desc[15],
                      i_req.first_level_desc[11:10]};
    assign sub     = (t2 == L2_LARGE) ? i_req.virt_addr[15:14] : i_req.virt_addr[11:10];
    assign sub_aps = i_req.second_level_desc[11:4];
    always_comb begin
        if (i_cfg.arch_v6) begin
            page_ap = {i_req.second_level_desc[9], i_req.second_level_desc[5:4]};
        end else begin
            page_ap = {1'b0, sub_aps[{sub, 1'b0} +: 2]};
        end
    end

    assign sec_ok  = i_cfg.arch_v6
                   ? perm_v6(sec_ap, i_req.privileged, wr)
                   : perm_v5(sec_ap[1:0], i_req.privileged, wr,
                             i_cfg.rom_protect, i_cfg.system_protect);
    assign page_ok = i_cfg.arch_v6
                   ? perm_v6(page_ap, i_req.privileged, wr)
                   : perm_v5(page_ap[1:0], i_req.privileged, wr,
                             i_cfg.rom_protect, i_cfg.system_protect);

    // descriptor decode and fault priority
    always_comb begin
        code    = CODE_NONE;
        unsup   = 1'b0;
        pa      = '0;
        dom_rep = dom;
        case (t1)
            L1_FAULT: begin
                code = CODE_SEC_TRANS;
                if (i_cfg.arch_v6) begin
                    dom_rep = 4'd0;
                end
            end
            L1_FINE: begin
                if (!i_cfg.arch_v6) begin
                    unsup = 1'b1;
                end else begin
                    code    = CODE_SEC_TRANS;
                    dom_rep = 4'd0;
                end
            end
            L1_SECTION: begin
                if (i_cfg.arch_v6 && i_req.first_level_desc[18]) begin
                    unsup = 1'b1;
                end else if (dom_fail) begin
                    code = CODE_SEC_DOM;
                end else if (dacc == DACC_CLIENT && !sec_ok) begin
                    code = CODE_SEC_PERM;
                end else begin
                    pa = {i_req.first_level_desc[31:20], i_req.virt_addr[19:0]};
                end
            end
            default: begin
                if (t2 == L2_FAULT) begin
                    code = CODE_PAGE_TRANS;
                end else if (dom_fail) begin
                    code = CODE_PAGE_DOM;
                end else if (dacc == DACC_CLIENT && !page_ok) begin
                    code = CODE_PAGE_PERM;
                end else if (t2 == L2_TINY) begin
                    unsup = 1'b1;
                end else if (t2 == L2_LARGE) begin
                    pa = {i_req.second_level_desc[31:16], i_req.virt_addr[15:0]};
                end else begin
                    pa = {i_req.second_level_desc[31:12], i_req.virt_addr[11:0]};
                end
            end
        endcase
    end

    // result assembly
    always_comb begin
        o_rsp = '0;
        if (!i_cfg.mmu_enable) begin
            o_rsp.phys_addr = i_req.virt_addr;
        end else if (unsup) begin
            o_rsp.unsupported = 1'b1;
        end else if (code == CODE_NONE) begin
            o_rsp.phys_addr = pa;
        end else begin
            o_rsp.fault_kind    = fetch ? KIND_FETCH : (wr ? KIND_WRITE : KIND_READ);
            o_rsp.fault_address = i_req.virt_addr;
            if (!i_cfg.arch_v6) begin
                o_rsp.fault_status   = {4'd0, dom_rep, code};
                o_rsp.set_data_regs  = i_req.record_fault;
                o_rsp.set_instr_regs = i_req.record_fault;
            end else if (fetch) begin
                o_rsp.fault_status   = {8'd0, code};
                o_rsp.set_instr_regs = i_req.record_fault;
            end else begin
                o_rsp.fault_status  = {wr, 3'd0, dom_rep, code};
                o_rsp.set_data_regs = i_req.record_fault;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/short_descriptor_translation_check.sv
// Short-descriptor translation check: one access per beat on the input stream, one
// result per access on the output stream, in order. An access is held in the input
// register, then the descriptor decode, domain and permission check run
// combinationally into the result register.
// Throughput is one access per cycle while the output is taken; a stalled output
// holds the result and the input register still takes one more beat. The
// configuration port is always ready and is meant to be written with the
// pipeline empty.
`default_nettype none

module short_descriptor_translation_check
    import sdtc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // access stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // virt_addr[31:0], first_level_desc[63:32], second_level_desc[95:64],
    // mode[97:96], privileged[98], record_fault[99], zero[103:100]
    input  wire logic [REQ_TDATA_W-1:0] i_s_tdata,
    // result stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // phys_addr[31:0], fault_kind[33:32], fault_status[45:34],
    // fault_address[77:46], set_data_regs[78], set_instr_regs[79],
    // unsupported[80], zero[87:81]
    output logic [RSP_TDATA_W-1:0]      o_m_tdata
);

    t_cfg w_cfg;
    t_req w_req_in;
    t_rsp w_rsp;

    logic r_s1_valid;
    logic r_s2_valid;
    t_req r_req;
    t_rsp r_rsp;
    logic s1_ready;
    logic s2_ready;

    sdtc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // unpack the input beat
    assign w_req_in.virt_addr         = i_s_tdata[31:0];
    assign w_req_in.first_level_desc  = i_s_tdata[63:32];
    assign w_req_in.second_level_desc = i_s_tdata[95:64];
    assign w_req_in.mode              = i_s_tdata[97:96];
    assign w_req_in.privileged        = i_s_tdata[98];
    assign w_req_in.record_fault      = i_s_tdata[99];

    // pipeline flow control
    assign s2_ready   = !r_s2_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_s_tready = s1_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_s_tvalid) begin
            r_req <= w_req_in;
        end
    end

    sdtc_check u_check (
        .i_cfg (w_cfg),
        .i_req (r_req),
        .o_rsp (w_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_rsp <= w_rsp;
        end
    end

    // pack the result beat
    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = {7'd0,
                         r_rsp.unsupported,
                         r_rsp.set_instr_regs,
                         r_rsp.set_data_regs,
                         r_rsp.fault_address,
                         r_rsp.fault_status,
                         r_rsp.fault_kind,
                         r_rsp.phys_addr};

    // an unsupported descriptor yields no address and no fault
    a_unsup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_rsp.unsupported |->
            r_rsp.phys_addr == '0 && r_rsp.fault_kind == KIND_NONE)
        else $error("unsupported result carries address or fault");

    // no fault means no status, no fault address and no register update
    a_nofault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_rsp.fault_kind == KIND_NONE |->
            r_rsp.fault_status == '0 && r_rsp.fault_address == '0 &&
            !r_rsp.set_data_regs && !r_rsp.set_instr_regs)
        else $error("fault fields set without a fault");

    // on v6 only a fetch fault writes the instruction fault registers
    a_v6_instr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && w_cfg.arch_v6 && r_rsp.set_instr_regs |->
            r_rsp.fault_kind == KIND_FETCH && !r_rsp.set_data_regs)
        else $error("v6 instruction fault registers set for a data access");

    // a full pipeline with a stalled output takes no input beat
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s2_valid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted with the pipeline full and stalled");

endmodule

`default_nettype wire

// File: dv/short_descriptor_translation_check_tb.sv
// testbench for the short descriptor translation check: predicted vs. returned translations
`timescale 1ns / 100ps

module short_descriptor_translation_check_tb;
    import sdtc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_LIMIT     = 5000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [REQ_TDATA_W-1:0] i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [RSP_TDATA_W-1:0] o_m_tdata;

    // local copy of the translation registers
    logic        mmu_on = 1'b0;
    logic        v6_rules = 1'b0;
    logic [31:0] dacc_word = '0;
    logic        rom_bit = 1'b0;
    logic        sys_bit = 1'b0;

    t_rsp translation_q[$];
    int   mismatch_cnt = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    int   rx_hold_cycles = 0;

    short_descriptor_translation_check DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // access permission decode for the active architecture
    function automatic logic ap_allows(input logic [2:0] ap, input logic kern,
                                       input logic wr);
        if (v6_rules) begin
            case (ap)
                3'd1:       return kern;
                3'd2:       return kern || !wr;
                3'd3:       return 1'b1;
                3'd5:       return kern && !wr;
                3'd6, 3'd7: return !wr;
                default:    return 1'b0;
            endcase
        end else begin
            case (ap[1:0])
                2'd0:    return rom_bit ? !wr : (sys_bit ? (kern && !wr) : 1'b0);
                2'd1:    return kern;
                2'd2:    return kern || !wr;
                default: return 1'b1;
            endcase
        end
    endfunction

    // expected result of one access under the current registers
    function automatic t_rsp predict_translation(input t_req a);
        t_rsp        r;
        logic [31:0] pa;
        logic [3:0]  code;
        logic [3:0]  dom;
        logic [1:0]  dacc;
        logic [1:0]  t2;
        logic [1:0]  sub;
        logic [2:0]  ap;
        logic        wr;
        logic        fetch;
        r     = '0;
        pa    = '0;
        code  = CODE_NONE;
        dom   = a.first_level_desc[8:5];
        wr    = (a.mode == MODE_WRITE);
        fetch = (a.mode == MODE_FETCH);
        if (!mmu_on) begin
            r.phys_addr = a.virt_addr;
            return r;
        end
        dacc = dacc_word[dom*2 +: 2];
        case (a.first_level_desc[1:0])
            L1_FAULT: begin
                code = CODE_SEC_TRANS;
                if (v6_rules) dom = '0;
            end
            L1_FINE: begin
                if (!v6_rules) begin
                    r.unsupported = 1'b1;
                    return r;
                end
                code = CODE_SEC_TRANS;
                dom  = '0;
            end
            L1_SECTION: begin
                if (v6_rules && a.first_level_desc[18]) begin
                    r.unsupported = 1'b1;
                    return r;
                end
                ap = {v6_rules & a.first_level_desc[15], a.first_level_desc[11:10]};
                if (dacc == DACC_NONE || dacc == DACC_RESERVED)
                    code = CODE_SEC_DOM;
                else if (dacc == DACC_CLIENT && !ap_allows(ap, a.privileged, wr))
                    code = CODE_SEC_PERM;
                else
                    pa = {a.first_level_desc[31:20], a.virt_addr[19:0]};
            end
            default: begin
                t2 = a.second_level_desc[1:0];
                if (t2 == L2_FAULT) begin
                    code = CODE_PAGE_TRANS;
                end else if (dacc == DACC_NONE || dacc == DACC_RESERVED) begin
                    code = CODE_PAGE_DOM;
                end else begin
                    if (v6_rules) begin
                        ap = {a.second_level_desc[9], a.second_level_desc[5:4]};
                    end else begin
                        sub = (t2 == L2_LARGE) ? a.virt_addr[15:14] : a.virt_addr[11:10];
                        ap  = {1'b0, a.second_level_desc[4 + 2*sub +: 2]};
                    end
                    if (dacc == DACC_CLIENT && !ap_allows(ap, a.privileged, wr)) begin
                        code = CODE_PAGE_PERM;
                    end else if (t2 == L2_TINY) begin
                        // tiny page only shows up once the checks have passed
                        r.unsupported = 1'b1;
                        return r;
                    end else if (t2 == L2_LARGE) begin
                        pa = {a.second_level_desc[31:16], a.virt_addr[15:0]};
                    end else begin
                        pa = {a.second_level_desc[31:12], a.virt_addr[11:0]};
                    end
                end
            end
        endcase
        if (code == CODE_NONE) begin
            r.phys_addr = pa;
            return r;
        end
        r.fault_kind    = fetch ? KIND_FETCH : (wr ? KIND_WRITE : KIND_READ);
        r.fault_address = a.virt_addr;
        if (!v6_rules) begin
            r.fault_status   = {4'b0, dom, code};
            r.set_data_regs  = a.record_fault;
            r.set_instr_regs = a.record_fault;
        end else if (fetch) begin
            r.fault_status   = {8'b0, code};
            r.set_instr_regs = a.record_fault;
        end else begin
            r.fault_status  = {wr, 3'b0, dom, code};
            r.set_data_regs = a.record_fault;
        end
        return r;
    endfunction

    function automatic t_req make_access(input logic [31:0] va, input logic [31:0] l1,
                                         input logic [31:0] l2, input logic [1:0] mode,
                                         input logic priv, input logic rec);
        t_req a;
        a.virt_addr         = va;
        a.first_level_desc  = l1;
        a.second_level_desc = l2;
        a.mode              = mode;
        a.privileged        = priv;
        a.record_fault      = rec;
        return a;
    endfunction

    // random access, mostly well-formed descriptors with random content
    function automatic t_req random_access();
        t_req a;
        int   pick;
        a.virt_addr         = $urandom;
        a.first_level_desc  = $urandom;
        a.second_level_desc = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 10)      a.first_level_desc[1:0] = L1_FAULT;
        else if (pick < 20) a.first_level_desc[1:0] = L1_FINE;
        else if (pick < 55) a.first_level_desc[1:0] = L1_SECTION;
        else                a.first_level_desc[1:0] = L1_COARSE;
        // keep supersections rare
        if ($urandom_range(0, 3) != 0) a.first_level_desc[18] = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 10)      a.second_level_desc[1:0] = L2_FAULT;
        else if (pick < 20) a.second_level_desc[1:0] = L2_TINY;
        else if (pick < 60) a.second_level_desc[1:0] = L2_LARGE;
        else                a.second_level_desc[1:0] = L2_SMALL;
        a.mode         = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        a.privileged   = 1'($urandom_range(0, 1));
        a.record_fault = 1'($urandom_range(0, 1));
        return a;
    endfunction

    // send one access beat and queue its prediction on acceptance
    task automatic send_access(input t_req a);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, a.record_fault, a.privileged, a.mode, a.second_level_desc,
                       a.first_level_desc, a.virt_addr};
        do @(posedge i_clk); while (!o_s_tready);
        translation_q.push_back(predict_translation(a));
    endtask

    // stop offering and wait for every predicted translation to come back
    task automatic drain();
        int n;
        n = 0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (translation_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MMU_ENABLE:     mmu_on    = val[0];
            CFG_ARCH_V6:        v6_rules  = val[0];
            CFG_DOMAIN_ACCESS:  dacc_word = val;
            CFG_ROM_PROTECT:    rom_bit   = val[0];
            CFG_SYSTEM_PROTECT: sys_bit   = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic mmu, input logic v6, input logic [31:0] dacc,
                                  input logic rom, input logic sys);
        drain();
        write_reg(CFG_MMU_ENABLE, {31'b0, mmu});
        write_reg(CFG_ARCH_V6, {31'b0, v6});
        write_reg(CFG_DOMAIN_ACCESS, dacc);
        write_reg(CFG_ROM_PROTECT, {31'b0, rom});
        write_reg(CFG_SYSTEM_PROTECT, {31'b0, sys});
    endtask

    // mmu off after reset: flat mapping, never a fault
    task automatic test_flat_mapping();
        send_access(make_access(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                                MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                2'd3, 1'b1, 1'b1));
    endtask

    // v5 rules, domain d gets access d mod 4 (none, client, reserved, manager)
    task automatic test_v5_rules();
        write_all_regs(1'b1, 1'b0, 32'he4e4_e4e4, 1'b0, 1'b0);
        // section client AP1: user denied, kernel allowed
        send_access(make_access(32'h1234_5678, 32'habc0_0422, '0, MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'h1234_5678, 32'habc0_0422, '0, MODE_READ, 1'b1, 1'b1));
        // AP0 without R and S bits denies even kernel reads
        send_access(make_access(32'h0000_0001, 32'habc0_0022, '0, MODE_READ, 1'b1, 1'b1));
        // manager ignores AP, no access and reserved domains fault
        send_access(make_access(32'h000f_ffff, 32'h1230_0062, '0, MODE_WRITE, 1'b0, 1'b1));
        send_access(make_access(32'h0000_0000, 32'h1230_0002, '0, MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'h0000_0000, 32'h1230_0042, '0, MODE_WRITE, 1'b1, 1'b1));
        // AP2 user write, AP3 all-ones address
        send_access(make_access(32'h0010_0000, 32'h0010_0822, '0, MODE_WRITE, 1'b0, 1'b1));
        send_access(make_access(32'hffff_ffff, 32'hfff0_0c22, '0, MODE_WRITE, 1'b0, 1'b1));
        // translation fault keeps the descriptor domain, fine table is unsupported
        send_access(make_access(32'h8000_0000, 32'h0000_01e0, '0, MODE_FETCH, 1'b0, 1'b1));
        send_access(make_access(32'h8000_0000, 32'h0000_0023, '0, MODE_READ, 1'b0, 1'b1));
        // page translation fault wins over the domain fault
        send_access(make_access(32'h0000_1000, 32'h0000_0001, 32'h0000_0000,
                                MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'h0000_1000, 32'h0000_0001, 32'h0000_0002,
                                MODE_READ, 1'b0, 1'b1));
        // large page subpage picked by va 15:14, small page by va 11:10
        send_access(make_access(32'h0000_8123, 32'h0000_0021, 32'h5678_0df1,
                                MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'h0000_8123, 32'h0000_0021, 32'h5678_0df1,
                                MODE_READ, 1'b1, 1'b0));
        send_access(make_access(32'h0000_0400, 32'h0000_0021, 32'h9abc_df32,
                                MODE_FETCH, 1'b1, 1'b0));
        // tiny page: unsupported once allowed, permission fault otherwise
        send_access(make_access(32'h0000_0000, 32'h0000_0021, 32'h0000_0ff3,
                                MODE_READ, 1'b1, 1'b1));
        send_access(make_access(32'h0000_0000, 32'h0000_0021, 32'h0000_0003,
                                2'd3, 1'b0, 1'b1));
        // R and S bits open AP0 for reads
        write_all_regs(1'b1, 1'b0, 32'he4e4_e4e4, 1'b1, 1'b1);
        send_access(make_access(32'h0000_0400, 32'h0000_0021, 32'h9abc_df32,
                                MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'h0000_0400, 32'h0000_0021, 32'h9abc_df32,
                                MODE_WRITE, 1'b1, 1'b1));
    endtask

    task automatic test_v6_rules();
        write_all_regs(1'b1, 1'b1, 32'he4e4_e4e4, 1'b0, 1'b0);
        // type three and fault descriptors report domain zero, write sets bit 11
        send_access(make_access(32'h4000_0000, 32'h0000_01e3, '0, MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'h4000_0000, 32'h0000_01e0, '0, MODE_WRITE, 1'b0, 1'b1));
        // supersection
        send_access(make_access(32'h4000_0000, 32'h0004_0022, '0, MODE_READ, 1'b1, 1'b1));
        // APX with AP1: kernel read only
        send_access(make_access(32'h0123_4567, 32'h0000_8422, '0, MODE_WRITE, 1'b1, 1'b1));
        send_access(make_access(32'h0123_4567, 32'h0000_8422, '0, MODE_READ, 1'b1, 1'b1));
        // fetch fault: instruction registers, code only
        send_access(make_access(32'h0000_0000, 32'h0000_0002, '0, MODE_FETCH, 1'b1, 1'b1));
        // page AP from bits 5:4 and APX from bit 9
        send_access(make_access(32'h0000_0abc, 32'h0000_0021, 32'h1111_1232,
                                MODE_WRITE, 1'b0, 1'b1));
        send_access(make_access(32'h0000_0abc, 32'h0000_0021, 32'h1111_1232,
                                MODE_READ, 1'b0, 1'b1));
        send_access(make_access(32'hffff_ffff, 32'h0000_0061, 32'h2222_0001,
                                MODE_WRITE, 1'b0, 1'b1));
        send_access(make_access(32'h0000_0000, 32'h0000_0021, 32'h0000_0033,
                                MODE_READ, 1'b0, 1'b1));
    endtask

    // random accesses over a series of register settings
    task automatic test_random_phases();
        logic [31:0] dacc;
        for (int p = 0; p < 10; p++) begin
            if (p == 0)      dacc = 32'h0000_0000;
            else if (p == 1) dacc = 32'hffff_ffff;
            else             dacc = $urandom;
            write_all_regs((p != 2), p[0], dacc, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            tx_idle = (p % 3 != 0);
            rx_idle = (p % 4 != 1);
            for (int n = 0; n < 50; n++) send_access(random_access());
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // long receiver hold-off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        write_all_regs(1'b1, 1'b0, $urandom, 1'b1, 1'b0);
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (int n = 0; n < 24; n++) send_access(random_access());
        drain();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int n = 0; n < 16; n++) send_access(random_access());
    endtask

    // result side ready pattern
    initial begin
        int stall;
        forever begin
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // compare every result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (translation_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %h",
                         $time, o_m_tdata);
                mismatch_cnt++;
            end else begin
                want = translation_q.pop_front();
                report_field("phys_addr", want.phys_addr, o_m_tdata[31:0]);
                report_field("fault_kind", 32'(want.fault_kind), 32'(o_m_tdata[33:32]));
                report_field("fault_status", 32'(want.fault_status), 32'(o_m_tdata[45:34]));
                report_field("fault_address", want.fault_address, o_m_tdata[77:46]);
                report_field("set_data_regs", 32'(want.set_data_regs), 32'(o_m_tdata[78]));
                report_field("set_instr_regs", 32'(want.set_instr_regs), 32'(o_m_tdata[79]));
                report_field("unsupported", 32'(want.unsupported), 32'(o_m_tdata[80]));
            end
        end
    end

    initial begin
        // hold reset, release on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_flat_mapping();
        test_v5_rules();
        test_v6_rules();
        test_random_phases();
        test_backpressure();
        drain();
        repeat (10) @(posedge i_clk);
        if (translation_q.size() != 0) begin
            $display("%0t: expected %0d more results, actual 0", $time, translation_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("[short_descriptor_translation_check] OK");
        end else begin
            $display("[short_descriptor_translation_check] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("[short_descriptor_translation_check] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/sdtc_pkg.sv
rtl/sdtc_cfg.sv
rtl/sdtc_check.sv
rtl/short_descriptor_translation_check.sv
dv/short_descriptor_translation_check_tb.sv
